/* rtl/sckx_pkg.sv */
`timescale 1ns / 1ps
package sckx_pkg;
    localparam int unsigned KeyBytes = 16;
    localparam int unsigned KsAddrW  = 4;
    localparam int unsigned CfgIdxW  = 2;
    localparam logic [CfgIdxW-1:0] CfgKeyFirst  = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgKeySecond = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgDataStart = 2'd2;

    localparam logic [159:0] ShaInit =
        160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

    // Round constant for a given round number.
    function automatic logic [31:0] f_round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20) begin
            k = 32'h5A827999;
        end else if (rnd < 7'd40) begin
            k = 32'h6ED9EBA1;
        end else if (rnd < 7'd60) begin
            k = 32'h8F1BBCDC;
        end else begin
            k = 32'hCA62C1D6;
        end
        return k;
    endfunction

    // Round function for a given round number.
    function automatic logic [31:0] f_round_f(input logic [6:0] rnd, input logic [31:0] b,
                                              input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction
endpackage

/* rtl/sckx_in_if.sv */
`timescale 1ns / 1ps
interface sckx_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        new_run;
    logic [63:0] run_position;
    modport source (output valid, data_byte, new_run, run_position, input ready);
    modport sink (input valid, data_byte, new_run, run_position, output ready);
endinterface

/* rtl/sckx_out_if.sv */
`timescale 1ns / 1ps
interface sckx_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    modport source (output valid, out_byte, input ready);
    modport sink (input valid, out_byte, output ready);
endinterface

/* rtl/sckx_ram.sv */
`timescale 1ns / 1ps
module sckx_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Single write port, registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* rtl/sha1_counter_keystream_xor_top.sv */
`timescale 1ns / 1ps
// SHA-1 counter-mode keystream XOR.
// Input channel: one data byte per transaction; a transaction with new_run set
// also carries the run's file position, which reloads the 64-bit block counter
// from (position - data_start) as signed 32 bits / 16, or 0 if not positive.
// Output channel: one transaction per input transaction, the byte XOR keystream.
// Configuration: write port, index 0/1 key halves, index 2 data start.
// Sequence: a byte that opens a 16-byte block first runs two SHA-1 compressions
// on one shared round unit, a load step, 80 rounds and an add each; the first
// 16 digest bytes are then written into a 16-entry keystream RAM, and the read
// and XOR follow. Every other byte goes through accept, RAM read and XOR. One
// byte is in work at a time, and the result register is loaded in the XOR step.
// The output register holds a result until it is taken; while it is full the
// block finishes the next byte up to the XOR and then waits.
// Reset clears the counter, the block position and the control state; the
// keystream RAM is not cleared since it is always written before it is read.
module sha1_counter_keystream_xor_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sckx_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [63:0]                  i_cfg_data,
    sckx_in_if.sink                      in_ch,
    sckx_out_if.source                   out_ch
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_ROUND = 7'b0000100,
        S_ADD   = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_READ  = 7'b0100000,
        S_XOR   = 7'b1000000
    } t_state;

    t_state         r_state, n_state;
    logic [63:0]    r_key0, r_key1, r_start;
    logic [63:0]    r_ctr, n_ctr;
    logic [sckx_pkg::KsAddrW-1:0] r_pos;
    logic [7:0]     r_data;
    logic           r_pass;       // 0: message block, 1: padding block
    logic [6:0]     r_rnd;
    logic [31:0]    r_w [16];
    logic [159:0]   r_h;          // chaining value
    logic [31:0]    r_a, r_b, r_c, r_d, r_e;
    logic [sckx_pkg::KsAddrW-1:0] r_widx;
    logic           r_ovalid;
    logic [7:0]     r_obyte;

    logic [511:0]   msg;
    logic [31:0]    wnew, wrnd, tsum;
    logic [31:0]    low;
    logic [7:0]     ks_wdata, ks_rdata;
    logic           ks_we;
    logic [127:0]   dig;

    // Message words: key halves, zeros, counter; or the fixed padding block.
    always_comb begin
        if (!r_pass) begin
            msg = {r_key0, r_key0, r_key1, r_key1, 192'd0, r_ctr};
        end else begin
            msg = {8'h80, 440'd0, 64'd512};
        end
    end

    assign wnew = {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} << 1 |
                  {r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0]} >> 31;
    assign wrnd = (r_rnd < 7'd16) ? r_w[r_rnd[3:0]] : wnew;
    assign tsum = {r_a[26:0], r_a[31:27]} + sckx_pkg::f_round_f(r_rnd, r_b, r_c, r_d)
                  + r_e + sckx_pkg::f_round_k(r_rnd) + wrnd;
    assign low  = 32'(in_ch.run_position - r_start);
    assign dig  = r_h[159:32];
    assign ks_we = (r_state == S_WRITE);
    assign ks_wdata = dig[8'(127 - 8 * r_widx) -: 8];

    sckx_ram #(.Width(8), .Depth(sckx_pkg::KeyBytes)) u_ks_ram (
        .i_clk  (i_clk),
        .i_we   (ks_we),
        .i_waddr(r_widx),
        .i_wdata(ks_wdata),
        .i_raddr(r_pos),
        .o_rdata(ks_rdata)
    );

    assign in_ch.ready  = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.out_byte = r_obyte;

    // Counter reload at a run start.
    always_comb begin
        n_ctr = r_ctr;
        if (in_ch.new_run) begin
            if (low != 32'd0 && !low[31]) begin
                n_ctr = {36'd0, low[31:4]};
            end else begin
                n_ctr = 64'd0;
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_ch.valid) begin
                    n_state = (in_ch.new_run || r_pos == 4'd0) ? S_LOAD : S_READ;
                end
            end
            S_LOAD:  n_state = S_ROUND;
            S_ROUND: n_state = (r_rnd == 7'd79) ? S_ADD : S_ROUND;
            S_ADD:   n_state = r_pass ? S_WRITE : S_LOAD;
            S_WRITE: n_state = (r_widx == 4'd15) ? S_READ : S_WRITE;
            S_READ:  n_state = S_XOR;
            S_XOR:   n_state = (!r_ovalid || out_ch.ready) ? S_IDLE : S_XOR;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ctr    <= 64'd0;
            r_pos    <= 4'd0;
            r_ovalid <= 1'b0;
            r_key0   <= 64'd0;
            r_key1   <= 64'd0;
            r_start  <= 64'd0;
            r_pass   <= 1'b0;
            r_rnd    <= 7'd0;
            r_widx   <= 4'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    sckx_pkg::CfgKeyFirst:  r_key0 <= i_cfg_data;
                    sckx_pkg::CfgKeySecond: r_key1 <= i_cfg_data;
                    sckx_pkg::CfgDataStart: r_start <= i_cfg_data;
                    default: ;
                endcase
            end
            // The output register fills from the XOR step and empties when taken.
            if (r_state == S_XOR && (!r_ovalid || out_ch.ready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_ctr  <= n_ctr;
                        r_pass <= 1'b0;
                        if (in_ch.new_run) begin
                            r_pos <= 4'd0;
                        end
                    end
                end
                S_LOAD:  r_rnd <= 7'd0;
                S_ROUND: r_rnd <= r_rnd + 7'd1;
                S_ADD: begin
                    if (r_pass) begin
                        r_ctr <= r_ctr + 64'd1;
                    end
                    r_pass <= 1'b1;
                    r_widx <= 4'd0;
                end
                S_WRITE: r_widx <= r_widx + 4'd1;
                S_XOR: begin
                    if (!r_ovalid || out_ch.ready) begin
                        r_pos <= r_pos + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers: schedule window, working variables, chaining value, data and output bytes.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_ch.valid) begin
            r_data <= in_ch.data_byte;
            r_h    <= sckx_pkg::ShaInit;
        end
        if (r_state == S_LOAD) begin
            for (int i = 0; i < 16; i++) begin
                r_w[i] <= msg[511 - 32 * i -: 32];
            end
            {r_a, r_b, r_c, r_d, r_e} <= r_h;
        end
        if (r_state == S_ROUND) begin
            if (r_rnd >= 7'd16) begin
                for (int i = 0; i < 15; i++) begin
                    r_w[i] <= r_w[i + 1];
                end
                r_w[15] <= wnew;
            end
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= tsum;
        end
        if (r_state == S_ADD) begin
            r_h <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                    r_h[63:32] + r_d, r_h[31:0] + r_e};
        end
        if (r_state == S_XOR && (!r_ovalid || out_ch.ready)) begin
            r_obyte <= r_data ^ ks_rdata;
        end
    end
endmodule

/* rtl/sckx_checker.sv */
`timescale 1ns / 1ps
module sckx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte
);
    // A held result keeps its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("output changed while stalled");

    // Intake stays closed through at least the read and XOR steps after an accepted transaction.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("input reopened too early");

    // A new result only appears right after the intake was closed for work.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without input");
endmodule

bind sha1_counter_keystream_xor_top sckx_checker u_sckx_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_byte (out_ch.out_byte)
);
